FILE: rtl/esc_pkg.sv
package esc_pkg;

  localparam int unsigned SecsWidth = 32;
  localparam int unsigned DaysWidth = 16;
  localparam int unsigned YearWidth = 12;

  localparam logic [SecsWidth-1:0] SecsPerDay  = 32'd86400;
  localparam logic [SecsWidth-1:0] SecsPerHour = 32'd3600;
  localparam logic [SecsWidth-1:0] SecsPerMin  = 32'd60;
  localparam logic [SecsWidth-1:0] DaysPerWeek = 32'd7;

  // Quotient bits minus one for each restoring division pass.
  localparam logic [3:0] DayDivLast  = 4'd15;
  localparam logic [3:0] HourDivLast = 4'd4;
  localparam logic [3:0] MinDivLast  = 4'd5;
  localparam logic [3:0] WdayDivLast = 4'd13;

  // 1970-01-01 was a Thursday.
  localparam logic [SecsWidth-1:0] EpochWeekday = 32'd4;

  localparam logic [YearWidth-1:0] EpochYear    = 12'd1970;
  localparam logic [6:0]           EpochMod100  = 7'd70;
  localparam logic [8:0]           EpochMod400  = 9'd370;
  localparam logic [6:0]           Mod100Last   = 7'd99;
  localparam logic [8:0]           Mod400Last   = 9'd399;

  localparam logic [SecsWidth-1:0] DaysCommon = 32'd365;
  localparam logic [SecsWidth-1:0] DaysLeap   = 32'd366;

  localparam logic [3:0] MonJan = 4'd0;
  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonDec = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_OUT
  } state_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]           pad;
    logic [2:0]           weekday;
    logic [5:0]           second;
    logic [5:0]           minute;
    logic [4:0]           hour;
    logic [4:0]           day_of_month;
    logic [3:0]           month;
    logic [YearWidth-1:0] year;
  } result_t;

  // Days in month, months counted from 0.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/epoch_seconds_to_calendar.sv
// Steps: day, hour, minute and weekday division passes, then year and month
//   stripping; every step is one pass through the shared 32-bit subtractor.
// Throughput: one beat at a time; a new input beat is taken once the result is
//   in the output register, even while that result still waits for m_tready.
// Reset: rst (synchronous, active high) clears the sequencer and m_tvalid.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] seconds_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [11:0] year, [15:12] month, [20:16] day_of_month,
                                 // [25:21] hour, [31:26] minute, [37:32] second,
                                 // [40:38] weekday, [47:41] zero
);

  localparam int unsigned W = esc_pkg::SecsWidth;

  esc_pkg::state_t state, state_next;

  // Working registers of the sequencer.
  logic [W-1:0]                     rem, rem_next;      // running remainder
  logic [W-1:0]                     dvs, dvs_next;      // shifted divisor
  logic [esc_pkg::DaysWidth-1:0]    quot, quot_next;    // quotient bits, shifted in
  logic [3:0]                       cnt, cnt_next;      // steps left in a division, less one
  logic [esc_pkg::DaysWidth-1:0]    days, days_next;
  logic [esc_pkg::YearWidth-1:0]    year, year_next;
  logic [6:0]                       ymod100, ymod100_next;
  logic [8:0]                       ymod400, ymod400_next;
  logic [3:0]                       mon, mon_next;
  logic [4:0]                       hour, hour_next;
  logic [5:0]                       minute, minute_next;
  logic [5:0]                       second, second_next;
  logic [2:0]                       weekday, weekday_next;

  esc_pkg::result_t result, result_next;
  logic             out_valid, out_valid_next;

  // Shared unit operands.
  logic [W-1:0] sub_b;
  logic [W-1:0] sub_diff;
  logic         sub_ge;
  logic         leap;
  logic         out_free;

  esc_sub_unit u_sub (
    .a    (rem),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Full 4/100/400 rule, tracked with year counters modulo 100 and 400.
  assign leap = (year[1:0] == 2'b00) && ((ymod100 != 7'd0) || (ymod400 == 9'd0));

  assign out_free = ~out_valid | m_tready;

  assign s_tready = (state == esc_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = result;

  // Subtrahend select: divisor for the division passes, year length, month length.
  always_comb begin
    case (state)
      esc_pkg::ST_YEAR:  sub_b = leap ? esc_pkg::DaysLeap : esc_pkg::DaysCommon;
      esc_pkg::ST_MONTH: sub_b = W'(esc_pkg::month_len(mon, leap));
      default:           sub_b = dvs;
    endcase
  end

  always_comb begin
    state_next     = state;
    rem_next       = rem;
    dvs_next       = dvs;
    quot_next      = quot;
    cnt_next       = cnt;
    days_next      = days;
    year_next      = year;
    ymod100_next   = ymod100;
    ymod400_next   = ymod400;
    mon_next       = mon;
    hour_next      = hour;
    minute_next    = minute;
    second_next    = second;
    weekday_next   = weekday;
    result_next    = result;
    out_valid_next = out_valid & ~m_tready;

    // Restoring division step shared by the four division passes.
    if (state == esc_pkg::ST_DAYS || state == esc_pkg::ST_HOUR ||
        state == esc_pkg::ST_MIN  || state == esc_pkg::ST_WDAY) begin
      if (sub_ge) begin
        rem_next = sub_diff;
      end
      quot_next = {quot[esc_pkg::DaysWidth-2:0], sub_ge};
      dvs_next  = dvs >> 1;
      cnt_next  = cnt - 4'd1;
    end

    case (state)
      esc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rem_next   = s_tdata;
          dvs_next   = esc_pkg::SecsPerDay << esc_pkg::DayDivLast;
          cnt_next   = esc_pkg::DayDivLast;
          quot_next  = '0;
          state_next = esc_pkg::ST_DAYS;
        end
      end
      esc_pkg::ST_DAYS: begin
        // Quotient is the day count, remainder the second of the day.
        if (cnt == 4'd0) begin
          days_next  = quot_next;
          dvs_next   = esc_pkg::SecsPerHour << esc_pkg::HourDivLast;
          cnt_next   = esc_pkg::HourDivLast;
          quot_next  = '0;
          state_next = esc_pkg::ST_HOUR;
        end
      end
      esc_pkg::ST_HOUR: begin
        if (cnt == 4'd0) begin
          hour_next  = quot_next[4:0];
          dvs_next   = esc_pkg::SecsPerMin << esc_pkg::MinDivLast;
          cnt_next   = esc_pkg::MinDivLast;
          quot_next  = '0;
          state_next = esc_pkg::ST_MIN;
        end
      end
      esc_pkg::ST_MIN: begin
        // Start the weekday pass on days + 4 (epoch was a Thursday).
        if (cnt == 4'd0) begin
          minute_next = quot_next[5:0];
          second_next = rem_next[5:0];
          rem_next    = W'(days) + esc_pkg::EpochWeekday;
          dvs_next    = esc_pkg::DaysPerWeek << esc_pkg::WdayDivLast;
          cnt_next    = esc_pkg::WdayDivLast;
          quot_next   = '0;
          state_next  = esc_pkg::ST_WDAY;
        end
      end
      esc_pkg::ST_WDAY: begin
        if (cnt == 4'd0) begin
          weekday_next = rem_next[2:0];
          rem_next     = W'(days);
          year_next    = esc_pkg::EpochYear;
          ymod100_next = esc_pkg::EpochMod100;
          ymod400_next = esc_pkg::EpochMod400;
          state_next   = esc_pkg::ST_YEAR;
        end
      end
      esc_pkg::ST_YEAR: begin
        // Strip one whole year per cycle.
        if (sub_ge) begin
          rem_next     = sub_diff;
          year_next    = year + 12'd1;
          ymod100_next = (ymod100 == esc_pkg::Mod100Last) ? 7'd0 : ymod100 + 7'd1;
          ymod400_next = (ymod400 == esc_pkg::Mod400Last) ? 9'd0 : ymod400 + 9'd1;
        end else begin
          mon_next   = esc_pkg::MonJan;
          state_next = esc_pkg::ST_MONTH;
        end
      end
      esc_pkg::ST_MONTH: begin
        // December absorbs whatever is left.
        if (sub_ge && mon != esc_pkg::MonDec) begin
          rem_next = sub_diff;
          mon_next = mon + 4'd1;
        end else begin
          state_next = esc_pkg::ST_OUT;
        end
      end
      esc_pkg::ST_OUT: begin
        // Hold until the output register is free, then load it.
        if (out_free) begin
          result_next.pad          = '0;
          result_next.weekday      = weekday;
          result_next.second       = second;
          result_next.minute       = minute;
          result_next.hour         = hour;
          result_next.day_of_month = rem[4:0] + 5'd1;
          result_next.month        = mon + 4'd1;
          result_next.year         = year;
          out_valid_next           = 1'b1;
          state_next               = esc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = esc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= esc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    dvs     <= dvs_next;
    quot    <= quot_next;
    cnt     <= cnt_next;
    days    <= days_next;
    year    <= year_next;
    ymod100 <= ymod100_next;
    ymod400 <= ymod400_next;
    mon     <= mon_next;
    hour    <= hour_next;
    minute  <= minute_next;
    second  <= second_next;
    weekday <= weekday_next;
    result  <= result_next;
  end

endmodule

FILE: rtl/esc_sub_unit.sv
// Shared compare-and-subtract: diff = a - b, ge set when a >= b.
module esc_sub_unit (
  input  logic [esc_pkg::SecsWidth-1:0] a,
  input  logic [esc_pkg::SecsWidth-1:0] b,
  output logic [esc_pkg::SecsWidth-1:0] diff,
  output logic                          ge
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

FILE: rtl/esc_checker.sv
module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Busy at the start of a conversion after an input beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken during conversion");

  // Date fields in range on every shown result.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] >= 4'd1 && m_tdata[15:12] <= 4'd12 &&
                 m_tdata[20:16] != 5'd0 && m_tdata[11:0] >= 12'd1970 &&
                 m_tdata[11:0] <= 12'd2106)
    else $error("date field out of range");

  // Time fields in range on every shown result.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:21] <= 5'd23 && m_tdata[31:26] <= 6'd59 &&
                 m_tdata[37:32] <= 6'd59 && m_tdata[40:38] <= 3'd6 &&
                 m_tdata[47:41] == 7'd0)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
